FILE: rtl/core/crsf_pkg.sv
// Shared types, constants and helper functions of the CRSF frame receiver.
package crsf_pkg;

  // Payload store geometry.
  localparam int PAYLOAD_DEPTH = 64;
  localparam int PAYLOAD_AW    = $clog2(PAYLOAD_DEPTH);

  // Frame layout.
  localparam logic [7:0] MIN_FRAME_LEN = 8'd2;
  localparam int         RC_PAYLOAD    = 22;
  localparam logic [5:0] RC_MIN_LEN    = 6'(RC_PAYLOAD + 2);
  localparam int         BYTE_IDX_W    = $clog2(RC_PAYLOAD + 1);

  // Frame types that the receiver accepts.
  localparam logic [7:0] FT_RC_CHANNELS = 8'h16;
  localparam logic [7:0] FT_PING        = 8'h28;
  localparam logic [7:0] FT_DEVICE_INFO = 8'h29;
  localparam logic [7:0] FT_PARAM_ENTRY = 8'h2B;
  localparam logic [7:0] FT_PARAM_READ  = 8'h2C;
  localparam logic [7:0] FT_PARAM_WRITE = 8'h2D;
  localparam logic [7:0] FT_COMMAND     = 8'h32;

  localparam logic [7:0] CRC_POLY = 8'hD5;

  // Channel packing.
  localparam int CHAN_W      = 11;
  localparam int CHAN_VAL_W  = 12;
  localparam int CHAN_COUNT  = 16;
  localparam int CHAN_IDX_W  = $clog2(CHAN_COUNT);
  localparam int SCALE_SPLIT = 4;
  localparam int ACC_W       = CHAN_W + 7;
  localparam int BITS_W      = $clog2(ACC_W + 1);

  // Scaling coefficients: gains are Q0.32, offsets Q12.32, rounded to nearest.
  localparam int PROD_W = CHAN_W + 32;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic [63:0] A0_FULL =
    ((64'd610873549 << 32) + 64'd500000000) / 64'd1000000000;
  localparam logic [63:0] A1_FULL =
    ((64'd624609619 << 32) + 64'd500000000) / 64'd1000000000;
  localparam logic [63:0] B0_FULL = (64'd894 << 32) +
    (((64'd208002443 << 32) + 64'd500000000) / 64'd1000000000);
  localparam logic [63:0] B1_FULL = (64'd881 << 32) +
    (((64'd199562773 << 32) + 64'd500000000) / 64'd1000000000);
  localparam logic [31:0]      SCALE_A0 = A0_FULL[31:0];
  localparam logic [31:0]      SCALE_A1 = A1_FULL[31:0];
  localparam logic [SUM_W-1:0] SCALE_B0 = B0_FULL[SUM_W-1:0];
  localparam logic [SUM_W-1:0] SCALE_B1 = B1_FULL[SUM_W-1:0];

  // Configuration register indexes.
  localparam logic [1:0] CFG_SCALE_ENABLE      = 2'd0;
  localparam logic [1:0] CFG_MAX_FRAME_LEN     = 2'd1;
  localparam logic [1:0] CFG_ADDRESS_PRIMARY   = 2'd2;
  localparam logic [1:0] CFG_ADDRESS_SECONDARY = 2'd3;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_CRC   = 3'd1,
    ST_LEN   = 3'd2,
    ST_TYPE  = 3'd3,
    ST_SHORT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_TYPE,
    PH_PAYLOAD,
    PH_CRC
  } parse_phase_t;

  typedef enum logic [2:0] {
    D_IDLE,
    D_FETCH,
    D_LOAD,
    D_MUL,
    D_ADD,
    D_OUT
  } dec_state_t;

  // One decoded channel offered by the unpacker to the output stage.
  typedef struct packed {
    logic                  valid;
    logic [CHAN_IDX_W-1:0] index;
    logic [CHAN_VAL_W-1:0] value;
    logic                  last;
  } chan_beat_t;

  // CRC-8, MSB first, one byte per call.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic type_ok(input logic [7:0] t);
    return t inside {FT_RC_CHANNELS, FT_PING, FT_DEVICE_INFO, FT_PARAM_ENTRY,
                     FT_PARAM_READ, FT_PARAM_WRITE, FT_COMMAND};
  endfunction

endpackage

FILE: rtl/core/crsf_if.sv
// Valid/ready channel interfaces for received bytes and frame results.
interface crsf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crsf_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  dest_address;
  logic [7:0]  frame_len;
  logic [7:0]  frame_type;
  logic        has_channel;
  logic [3:0]  chan_index;
  logic [11:0] chan_value;
  logic        last;

  modport source (output valid, output status, output dest_address, output frame_len,
                  output frame_type, output has_channel, output chan_index,
                  output chan_value, output last, input ready);
  modport sink (input valid, input status, input dest_address, input frame_len,
                input frame_type, input has_channel, input chan_index,
                input chan_value, input last, output ready);
endinterface

FILE: rtl/core/crsf_payload_ram.sv
// Single-port-write, single-port-read synchronous RAM for the frame payload.
module crsf_payload_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/crsf_chan_unpack.sv
// Reads the RC payload from the store and unpacks, optionally scales, sixteen channels.
module crsf_chan_unpack
  import crsf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  scale_en,
  output logic                  rd_en,
  output logic [PAYLOAD_AW-1:0] rd_addr,
  input  logic [7:0]            rd_data,
  input  logic                  take,
  output chan_beat_t            beat,
  output logic                  busy
);

  dec_state_t            state_r, state_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [BITS_W-1:0]     bits_r, bits_nxt;
  logic [BYTE_IDX_W-1:0] byte_idx_r, byte_idx_nxt;
  logic [CHAN_IDX_W-1:0] idx_r, idx_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [CHAN_VAL_W-1:0] value_r, value_nxt;

  logic [CHAN_W-1:0] raw;
  logic [31:0]       gain;
  logic [SUM_W-1:0]  offset;
  logic [SUM_W-1:0]  sum;

  // The first four channels use their own gain and offset.
  assign raw    = acc_r[CHAN_W-1:0];
  assign gain   = (idx_r < CHAN_IDX_W'(SCALE_SPLIT)) ? SCALE_A0 : SCALE_A1;
  assign offset = (idx_r < CHAN_IDX_W'(SCALE_SPLIT)) ? SCALE_B0 : SCALE_B1;
  assign sum    = SUM_W'(prod_r) + offset;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    bits_r     <= bits_nxt;
    byte_idx_r <= byte_idx_nxt;
    idx_r      <= idx_nxt;
    prod_r     <= prod_nxt;
    value_r    <= value_nxt;
  end

  // Next state and datapath.
  always_comb begin
    state_nxt    = state_r;
    acc_nxt      = acc_r;
    bits_nxt     = bits_r;
    byte_idx_nxt = byte_idx_r;
    idx_nxt      = idx_r;
    prod_nxt     = prod_r;
    value_nxt    = value_r;
    case (state_r)
      D_IDLE: begin
        if (start) begin
          acc_nxt      = '0;
          bits_nxt     = '0;
          byte_idx_nxt = '0;
          idx_nxt      = '0;
          state_nxt    = D_FETCH;
        end
      end
      D_FETCH: begin
        state_nxt = D_LOAD;
      end
      D_LOAD: begin
        // Bytes arrive least significant bit first behind the bits still held.
        acc_nxt      = acc_r | (ACC_W'(rd_data) << bits_r);
        bits_nxt     = bits_r + BITS_W'(8);
        byte_idx_nxt = byte_idx_r + 1'b1;
        state_nxt    = (bits_nxt >= BITS_W'(CHAN_W)) ? D_MUL : D_FETCH;
      end
      D_MUL: begin
        acc_nxt   = acc_r >> CHAN_W;
        bits_nxt  = bits_r - BITS_W'(CHAN_W);
        value_nxt = CHAN_VAL_W'(raw);
        prod_nxt  = PROD_W'(gain) * PROD_W'(raw);
        state_nxt = scale_en ? D_ADD : D_OUT;
      end
      D_ADD: begin
        value_nxt = sum[SUM_W-1:32];
        state_nxt = D_OUT;
      end
      D_OUT: begin
        if (take) begin
          if (idx_r == CHAN_IDX_W'(CHAN_COUNT - 1)) begin
            state_nxt = D_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = D_FETCH;
          end
        end
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    rd_en      = (state_r == D_FETCH);
    rd_addr    = PAYLOAD_AW'(byte_idx_r);
    beat.valid = (state_r == D_OUT);
    beat.index = idx_r;
    beat.value = value_r;
    beat.last  = (idx_r == CHAN_IDX_W'(CHAN_COUNT - 1));
    busy       = (state_r != D_IDLE);
  end

endmodule

FILE: rtl/core/crsf_frame_receiver.sv
// CRSF frame receiver: byte parser, payload store, channel unpacker and result register.
// A single-beat result is registered and is on the output the cycle after its byte is taken.
// For a good RC frame the unpacker fetches and loads payload bytes, forms each channel, scales
// it when scaling is on and offers it to the result register. Bytes are taken one per cycle
// while the result register is free and the unpacker is idle. The unpacker starts the next
// channel once its beat is taken, and no byte is taken until the sixteenth beat has gone.
// Reset: synchronous, active low; parser hunts, configuration returns to its defaults.
module crsf_frame_receiver
  import crsf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  crsf_byte_if.sink           in_if,
  crsf_result_if.source       out_if,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  // Configuration registers.
  logic       scale_en_r;
  logic [5:0] max_len_r;
  logic [7:0] addr_pri_r;
  logic [7:0] addr_sec_r;

  // Parser state.
  parse_phase_t phase_r, phase_nxt;
  logic [7:0]   held_address_r, held_address_nxt;
  logic [5:0]   held_length_r, held_length_nxt;
  logic [7:0]   held_type_r, held_type_nxt;
  logic [5:0]   count_r, count_nxt;
  logic [7:0]   crc_r, crc_nxt;

  // Result register.
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [7:0]            out_address_r;
  logic [7:0]            out_len_r;
  logic [7:0]            out_type_r;
  logic                  out_has_r;
  logic [CHAN_IDX_W-1:0] out_index_r;
  logic [CHAN_VAL_W-1:0] out_value_r;
  logic                  out_last_r;

  logic       out_free;
  logic       in_take;
  logic [7:0] rx;
  logic       len_bad;
  logic [5:0] count_inc;

  logic       res_valid;
  status_t    res_status;
  logic [7:0] res_len;
  logic [7:0] res_type;
  logic       dec_start;

  logic                  ram_we;
  logic                  ram_re;
  logic [PAYLOAD_AW-1:0] ram_raddr;
  logic [7:0]            ram_rdata;
  chan_beat_t            beat;
  logic                  dec_busy;
  logic                  dec_take;

  // The result register is free when empty or being emptied in this cycle. Bytes are
  // held off while the unpacker reads the store, so the parser never writes an entry
  // that is being read.
  assign out_free    = !out_valid_r || out_if.ready;
  assign in_if.ready = out_free && !dec_busy;
  assign in_take     = in_if.valid && in_if.ready;
  assign rx          = in_if.rx_byte;
  assign dec_take    = beat.valid && out_free;
  assign count_inc   = count_r + 1'b1;

  // A length byte fails when it is below the minimum, above the configured maximum or
  // would carry more payload than the store can hold.
  assign len_bad = (rx < MIN_FRAME_LEN) || (rx > {2'b00, max_len_r}) ||
                   (32'(rx) > PAYLOAD_DEPTH + 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_en_r <= 1'b0;
      max_len_r  <= 6'd62;
      addr_pri_r <= 8'd200;
      addr_sec_r <= 8'd236;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE_ENABLE:      scale_en_r <= cfg_data[0];
        CFG_MAX_FRAME_LEN:     max_len_r  <= cfg_data[5:0];
        CFG_ADDRESS_PRIMARY:   addr_pri_r <= cfg_data;
        CFG_ADDRESS_SECONDARY: addr_sec_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      held_address_r <= '0;
      held_length_r  <= '0;
      held_type_r    <= '0;
      count_r        <= '0;
      crc_r          <= '0;
    end else begin
      phase_r        <= phase_nxt;
      held_address_r <= held_address_nxt;
      held_length_r  <= held_length_nxt;
      held_type_r    <= held_type_nxt;
      count_r        <= count_nxt;
      crc_r          <= crc_nxt;
    end
  end

  // Parser next state. The CRC covers the type byte and every payload byte.
  always_comb begin
    phase_nxt        = phase_r;
    held_address_nxt = held_address_r;
    held_length_nxt  = held_length_r;
    held_type_nxt    = held_type_r;
    count_nxt        = count_r;
    crc_nxt          = crc_r;
    if (in_take) begin
      case (phase_r)
        PH_HUNT: begin
          if (rx == addr_pri_r || rx == addr_sec_r) begin
            held_address_nxt = rx;
            phase_nxt        = PH_LEN;
          end
        end
        PH_LEN: begin
          if (len_bad) begin
            phase_nxt = PH_HUNT;
          end else begin
            held_length_nxt = rx[5:0];
            phase_nxt       = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (!type_ok(rx)) begin
            phase_nxt = PH_HUNT;
          end else begin
            held_type_nxt = rx;
            crc_nxt       = crc8_step(8'h00, rx);
            count_nxt     = '0;
            // A frame of type byte alone goes straight to its CRC byte.
            phase_nxt     = (held_length_r <= 6'(MIN_FRAME_LEN)) ? PH_CRC : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_nxt   = crc8_step(crc_r, rx);
          count_nxt = count_inc;
          if (({1'b0, count_inc} + 7'd2) >= {1'b0, held_length_r}) begin
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          phase_nxt = PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  // Parser outputs: a single-beat result, or the start of channel unpacking.
  always_comb begin
    res_valid  = 1'b0;
    res_status = ST_OK;
    res_len    = {2'b00, held_length_r};
    res_type   = held_type_r;
    dec_start  = 1'b0;
    if (in_take) begin
      case (phase_r)
        PH_LEN: begin
          if (len_bad) begin
            res_valid  = 1'b1;
            res_status = ST_LEN;
            res_len    = rx;
            res_type   = 8'h00;
          end
        end
        PH_TYPE: begin
          if (!type_ok(rx)) begin
            res_valid  = 1'b1;
            res_status = ST_TYPE;
            res_type   = rx;
          end
        end
        PH_CRC: begin
          if (rx != crc_r) begin
            res_valid  = 1'b1;
            res_status = ST_CRC;
          end else if (held_type_r != FT_RC_CHANNELS) begin
            res_valid  = 1'b1;
            res_status = ST_OK;
          end else if (held_length_r < RC_MIN_LEN) begin
            // An RC frame too short to hold all sixteen channels.
            res_valid  = 1'b1;
            res_status = ST_SHORT;
          end else begin
            dec_start = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign ram_we = in_take && (phase_r == PH_PAYLOAD) && (32'(count_r) < PAYLOAD_DEPTH);

  crsf_payload_ram #(
    .DEPTH (PAYLOAD_DEPTH),
    .WIDTH (8)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (PAYLOAD_AW'(count_r)),
    .wr_data (rx),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  crsf_chan_unpack u_unpack (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dec_start),
    .scale_en (scale_en_r),
    .rd_en    (ram_re),
    .rd_addr  (ram_raddr),
    .rd_data  (ram_rdata),
    .take     (dec_take),
    .beat     (beat),
    .busy     (dec_busy)
  );

  // Result register. A parser result and a channel beat never compete: bytes are not
  // taken while the unpacker is busy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid || dec_take) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_status_r  <= res_status;
      out_address_r <= held_address_r;
      out_len_r     <= res_len;
      out_type_r    <= res_type;
      out_has_r     <= 1'b0;
      out_index_r   <= '0;
      out_value_r   <= '0;
      out_last_r    <= 1'b1;
    end else if (dec_take) begin
      out_status_r  <= ST_OK;
      out_address_r <= held_address_r;
      out_len_r     <= {2'b00, held_length_r};
      out_type_r    <= held_type_r;
      out_has_r     <= 1'b1;
      out_index_r   <= beat.index;
      out_value_r   <= beat.value;
      out_last_r    <= beat.last;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.dest_address = out_address_r;
  assign out_if.frame_len    = out_len_r;
  assign out_if.frame_type   = out_type_r;
  assign out_if.has_channel  = out_has_r;
  assign out_if.chan_index   = out_index_r;
  assign out_if.chan_value   = out_value_r;
  assign out_if.last         = out_last_r;

endmodule
